// File: rtl/core/ssg_pkg.sv
// Shared constants for the share generator: register indexes, field widths,
// reset values and pipeline latencies.
// No dependencies.
package ssg_pkg;

    localparam int DEF_MAX_DEGREE = 7;
    localparam int DEF_VALUE_BITS = 16;

    localparam int COEFF_FIELDS   = 7;
    localparam int MOD_FIELD_BITS = 16;
    localparam int DEG_BITS       = 3;
    localparam int IDX_BITS       = 1;
    localparam int X_BITS         = 8;

    localparam logic [IDX_BITS-1:0] REG_MODULUS = 1'b0;
    localparam logic [IDX_BITS-1:0] REG_DEGREE  = 1'b1;

    localparam logic [MOD_FIELD_BITS-1:0] MOD_RESET = 16'd127;
    localparam logic [DEG_BITS-1:0]       DEG_RESET = 3'd2;

    // reducer: multiply by reciprocal, multiply by modulus, subtract and correct
    localparam int RED_LAT  = 3;
    // Horner step: add and correct, multiply, reduce
    localparam int STEP_LAT = 2 + RED_LAT;

endpackage

// File: rtl/core/shamir_share_generator.sv
// Shamir share generator top level: config registers, reduction lanes, Horner chain.
// Uses ssg_pkg, ssg_recip, ssg_modred and ssg_horner.
//
// Takes one share request per cycle (start while busy is low) and returns
// f(x) mod modulus on o_share with a one-cycle o_share_valid strobe. The receiver
// cannot stall, so the strobe must be taken when it appears. The share index,
// the secret and each coefficient up to MAX_DEGREE are first reduced in their own
// Barrett lanes; a chain of Horner steps then merges them. The reducers work
// from a reciprocal of the modulus that a serial unit builds one bit a cycle,
// so busy is high and the config port is not ready while it runs, after reset
// and after each modulus write.
module shamir_share_generator #(
    parameter int MAX_DEGREE = ssg_pkg::DEF_MAX_DEGREE,
    parameter int VALUE_BITS = ssg_pkg::DEF_VALUE_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [ssg_pkg::X_BITS-1:0]          i_share_index,
    input  logic [VALUE_BITS-1:0]               i_secret,
    input  logic [VALUE_BITS-1:0]               i_coeff_1,
    input  logic [VALUE_BITS-1:0]               i_coeff_2,
    input  logic [VALUE_BITS-1:0]               i_coeff_3,
    input  logic [VALUE_BITS-1:0]               i_coeff_4,
    input  logic [VALUE_BITS-1:0]               i_coeff_5,
    input  logic [VALUE_BITS-1:0]               i_coeff_6,
    input  logic [VALUE_BITS-1:0]               i_coeff_7,
    output logic                                o_share_valid,
    output logic [ssg_pkg::MOD_FIELD_BITS-1:0]  o_share,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ssg_pkg::IDX_BITS-1:0]        i_cfg_index,
    input  logic [ssg_pkg::MOD_FIELD_BITS-1:0]  i_cfg_data
);
    localparam int MB    = (VALUE_BITS < ssg_pkg::MOD_FIELD_BITS) ? VALUE_BITS
                           : ssg_pkg::MOD_FIELD_BITS;
    localparam int RW    = 2 * MB;
    localparam int NSTEP = (MAX_DEGREE < ssg_pkg::COEFF_FIELDS) ? MAX_DEGREE
                           : ssg_pkg::COEFF_FIELDS;
    localparam int LAT   = ssg_pkg::RED_LAT + ssg_pkg::STEP_LAT * NSTEP + 1;

    logic [MB-1:0]                r_mod;
    logic [ssg_pkg::DEG_BITS-1:0] r_deg;
    logic [LAT-1:0]               r_vld;
    logic [MB-1:0]                r_share;
    logic [MB-1:0]                r_sd [0:ssg_pkg::STEP_LAT*NSTEP-1];

    logic                         w_recip_busy;
    logic [RW-1:0]                w_mu;
    logic                         w_cfg_wr;
    logic                         w_accept;

    logic [VALUE_BITS-1:0]        w_coeff [1:ssg_pkg::COEFF_FIELDS];
    logic [MB-1:0]                w_x_red;
    logic [MB-1:0]                w_sec_red;
    logic [MB-1:0]                w_sec_dly;
    logic [MB-1:0]                w_c_red [1:NSTEP];
    logic [MB-1:0]                w_acc   [0:NSTEP];
    logic [MB:0]                  w_fin;
    logic [MB:0]                  n_fin;

    assign w_cfg_wr = i_cfg_valid && o_cfg_ready;
    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= ssg_pkg::MOD_RESET[MB-1:0];
            r_deg <= ssg_pkg::DEG_RESET;
        end else if (w_cfg_wr) begin
            if (i_cfg_index == ssg_pkg::REG_MODULUS) begin
                r_mod <= i_cfg_data[MB-1:0];
            end else begin
                r_deg <= i_cfg_data[ssg_pkg::DEG_BITS-1:0];
            end
        end
    end

    ssg_recip #(
        .VALUE_BITS (VALUE_BITS)
    ) u_recip (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (w_cfg_wr && (i_cfg_index == ssg_pkg::REG_MODULUS)),
        .i_m       (r_mod),
        .o_busy    (w_recip_busy),
        .o_mu      (w_mu)
    );

    assign busy        = w_recip_busy;
    assign o_cfg_ready = !w_recip_busy;

    assign w_coeff[1] = i_coeff_1;
    assign w_coeff[2] = i_coeff_2;
    assign w_coeff[3] = i_coeff_3;
    assign w_coeff[4] = i_coeff_4;
    assign w_coeff[5] = i_coeff_5;
    assign w_coeff[6] = i_coeff_6;
    assign w_coeff[7] = i_coeff_7;

    // reduction lanes
    ssg_modred #(
        .VALUE_BITS (VALUE_BITS)
    ) u_lane_x (
        .i_clk (i_clk),
        .i_a   (RW'(i_share_index)),
        .i_m   (r_mod),
        .i_mu  (w_mu),
        .o_r   (w_x_red)
    );

    ssg_modred #(
        .VALUE_BITS (VALUE_BITS)
    ) u_lane_sec (
        .i_clk (i_clk),
        .i_a   (RW'(i_secret)),
        .i_m   (r_mod),
        .i_mu  (w_mu),
        .o_r   (w_sec_red)
    );

    genvar k;
    generate
        for (k = 1; k <= NSTEP; k++) begin : g_lane
            logic [VALUE_BITS-1:0] w_cin;
            // coefficients above the degree enter as zero
            assign w_cin = (ssg_pkg::DEG_BITS'(k) <= r_deg) ? w_coeff[k] : '0;
            ssg_modred #(
                .VALUE_BITS (VALUE_BITS)
            ) u_lane_c (
                .i_clk (i_clk),
                .i_a   (RW'(w_cin)),
                .i_m   (r_mod),
                .i_mu  (w_mu),
                .o_r   (w_c_red[k])
            );
        end
    endgenerate

    // Horner chain, highest coefficient first; lane values delayed to meet it
    assign w_acc[0] = '0;

    genvar s, t;
    generate
        for (s = 0; s < NSTEP; s++) begin : g_step
            logic [MB-1:0] w_c_in;
            logic [MB-1:0] w_x_in;
            if (s == 0) begin : g_nodly
                assign w_c_in = w_c_red[NSTEP];
                assign w_x_in = w_x_red;
            end else begin : g_dly
                logic [MB-1:0] r_cd [0:ssg_pkg::STEP_LAT*s-1];
                logic [MB-1:0] r_xd [0:ssg_pkg::STEP_LAT*s-1];
                always_ff @(posedge i_clk) begin
                    r_cd[0] <= w_c_red[NSTEP-s];
                    r_xd[0] <= w_x_red;
                end
                for (t = 1; t < ssg_pkg::STEP_LAT*s; t++) begin : g_tap
                    always_ff @(posedge i_clk) begin
                        r_cd[t] <= r_cd[t-1];
                        r_xd[t] <= r_xd[t-1];
                    end
                end
                assign w_c_in = r_cd[ssg_pkg::STEP_LAT*s-1];
                assign w_x_in = r_xd[ssg_pkg::STEP_LAT*s-1];
            end

            ssg_horner #(
                .VALUE_BITS (VALUE_BITS)
            ) u_step (
                .i_clk  (i_clk),
                .i_acc  (w_acc[s]),
                .i_coef (w_c_in),
                .i_x    (w_x_in),
                .i_m    (r_mod),
                .i_mu   (w_mu),
                .o_acc  (w_acc[s+1])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        r_sd[0] <= w_sec_red;
    end

    generate
        for (t = 1; t < ssg_pkg::STEP_LAT*NSTEP; t++) begin : g_sec_tap
            always_ff @(posedge i_clk) begin
                r_sd[t] <= r_sd[t-1];
            end
        end
    endgenerate

    assign w_sec_dly = r_sd[ssg_pkg::STEP_LAT*NSTEP-1];

    // merge: add the constant term; modulus below two gives zero
    assign w_fin = {1'b0, w_acc[NSTEP]} + {1'b0, w_sec_dly};
    assign n_fin = (w_fin >= {1'b0, r_mod}) ? (w_fin - {1'b0, r_mod}) : w_fin;

    always_ff @(posedge i_clk) begin
        r_share <= (r_mod < MB'(2)) ? '0 : n_fin[MB-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], w_accept};
        end
    end

    assign o_share_valid = r_vld[LAT-1];
    assign o_share       = ssg_pkg::MOD_FIELD_BITS'(r_share);

    a_share_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LAT o_share_valid)
        else $error("share strobe missing after accepted request");

    a_share_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_share_valid && (r_mod >= MB'(2))) |-> (o_share < ssg_pkg::MOD_FIELD_BITS'(r_mod)))
        else $error("share not reduced below modulus");

    a_recip_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cfg_wr && (i_cfg_index == ssg_pkg::REG_MODULUS)) |=> busy)
        else $error("modulus write did not restart reciprocal");

    a_reset_quiet: assert property (@(posedge i_clk)
        (i_rst_n && !$past(i_rst_n)) |-> !o_share_valid)
        else $error("share strobe straight after reset");

endmodule

// File: rtl/core/ssg_recip.sv
// Serial reciprocal unit: floor(2^(2*MB) / modulus), one quotient bit a cycle.
// Runs after reset and after every modulus write. Uses ssg_pkg.
module ssg_recip #(
    parameter int VALUE_BITS = ssg_pkg::DEF_VALUE_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_restart,
    input  logic [((VALUE_BITS < ssg_pkg::MOD_FIELD_BITS) ? VALUE_BITS
                   : ssg_pkg::MOD_FIELD_BITS)-1:0] i_m,
    output logic                                  o_busy,
    output logic [2*((VALUE_BITS < ssg_pkg::MOD_FIELD_BITS) ? VALUE_BITS
                   : ssg_pkg::MOD_FIELD_BITS)-1:0] o_mu
);
    localparam int MB = (VALUE_BITS < ssg_pkg::MOD_FIELD_BITS) ? VALUE_BITS
                        : ssg_pkg::MOD_FIELD_BITS;
    localparam int RW = 2 * MB;
    localparam int CW = $clog2(RW + 1);

    logic          r_run;
    logic [CW-1:0] r_cnt;
    logic [MB-1:0] r_rem;
    logic [RW-1:0] r_q;

    logic          w_bit;
    logic [MB:0]   w_sh;
    logic          w_ge;
    logic [MB:0]   n_rem;

    assign w_bit = (r_cnt == CW'(RW));
    assign w_sh  = {r_rem, w_bit};
    assign w_ge  = (w_sh >= {1'b0, i_m});
    assign n_rem = w_ge ? (w_sh - {1'b0, i_m}) : w_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b1;
            r_cnt <= CW'(RW);
            r_rem <= '0;
        end else if (i_restart) begin
            r_run <= 1'b1;
            r_cnt <= CW'(RW);
            r_rem <= '0;
        end else if (r_run) begin
            r_rem <= n_rem[MB-1:0];
            if (r_cnt == '0) begin
                r_run <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_run && !i_restart) begin
            r_q <= {r_q[RW-2:0], w_ge};
        end
    end

    assign o_busy = r_run;
    assign o_mu   = r_q;

endmodule

// File: rtl/core/ssg_modred.sv
// Pipelined Barrett reducer: a mod m for a < 2^(2*MB), three stages.
// Needs the reciprocal from ssg_recip. Uses ssg_pkg.
module ssg_modred #(
    parameter int VALUE_BITS = ssg_pkg::DEF_VALUE_BITS
) (
    input  logic                                  i_clk,
    input  logic [2*((VALUE_BITS < ssg_pkg::MOD_FIELD_BITS) ? VALUE_BITS
                   : ssg_pkg::MOD_FIELD_BITS)-1:0] i_a,
    input  logic [((VALUE_BITS < ssg_pkg::MOD_FIELD_BITS) ? VALUE_BITS
                   : ssg_pkg::MOD_FIELD_BITS)-1:0] i_m,
    input  logic [2*((VALUE_BITS < ssg_pkg::MOD_FIELD_BITS) ? VALUE_BITS
                   : ssg_pkg::MOD_FIELD_BITS)-1:0] i_mu,
    output logic [((VALUE_BITS < ssg_pkg::MOD_FIELD_BITS) ? VALUE_BITS
                   : ssg_pkg::MOD_FIELD_BITS)-1:0] o_r
);
    localparam int MB = (VALUE_BITS < ssg_pkg::MOD_FIELD_BITS) ? VALUE_BITS
                        : ssg_pkg::MOD_FIELD_BITS;
    localparam int RW = 2 * MB;

    logic [2*RW-1:0] r_p1;
    logic [MB:0]     r_a1;
    logic [MB:0]     r_t2;
    logic [MB:0]     r_a2;
    logic [MB-1:0]   r_r;

    logic [MB:0]     w_q;
    logic [2*MB:0]   w_qm;
    logic [MB:0]     w_d;
    logic [MB:0]     n_r;

    // quotient estimate is low by at most one, so one correction suffices
    assign w_q  = r_p1[RW +: (MB + 1)];
    assign w_qm = w_q * i_m;
    assign w_d  = r_a2 - r_t2;
    assign n_r  = (w_d >= {1'b0, i_m}) ? (w_d - {1'b0, i_m}) : w_d;

    always_ff @(posedge i_clk) begin
        r_p1 <= i_a * i_mu;
        r_a1 <= i_a[MB:0];
        r_t2 <= w_qm[MB:0];
        r_a2 <= r_a1;
        r_r  <= n_r[MB-1:0];
    end

    assign o_r = r_r;

endmodule

// File: rtl/core/ssg_horner.sv
// One Horner step: ((acc + c) mod m) * x mod m, five stages.
// Uses ssg_modred and ssg_pkg.
module ssg_horner #(
    parameter int VALUE_BITS = ssg_pkg::DEF_VALUE_BITS
) (
    input  logic                                  i_clk,
    input  logic [((VALUE_BITS < ssg_pkg::MOD_FIELD_BITS) ? VALUE_BITS
                   : ssg_pkg::MOD_FIELD_BITS)-1:0] i_acc,
    input  logic [((VALUE_BITS < ssg_pkg::MOD_FIELD_BITS) ? VALUE_BITS
                   : ssg_pkg::MOD_FIELD_BITS)-1:0] i_coef,
    input  logic [((VALUE_BITS < ssg_pkg::MOD_FIELD_BITS) ? VALUE_BITS
                   : ssg_pkg::MOD_FIELD_BITS)-1:0] i_x,
    input  logic [((VALUE_BITS < ssg_pkg::MOD_FIELD_BITS) ? VALUE_BITS
                   : ssg_pkg::MOD_FIELD_BITS)-1:0] i_m,
    input  logic [2*((VALUE_BITS < ssg_pkg::MOD_FIELD_BITS) ? VALUE_BITS
                   : ssg_pkg::MOD_FIELD_BITS)-1:0] i_mu,
    output logic [((VALUE_BITS < ssg_pkg::MOD_FIELD_BITS) ? VALUE_BITS
                   : ssg_pkg::MOD_FIELD_BITS)-1:0] o_acc
);
    localparam int MB = (VALUE_BITS < ssg_pkg::MOD_FIELD_BITS) ? VALUE_BITS
                        : ssg_pkg::MOD_FIELD_BITS;
    localparam int RW = 2 * MB;

    logic [MB-1:0] r_sum;
    logic [MB-1:0] r_x;
    logic [RW-1:0] r_prod;

    logic [MB:0]   w_sum;
    logic [MB:0]   n_sum;

    assign w_sum = {1'b0, i_acc} + {1'b0, i_coef};
    assign n_sum = (w_sum >= {1'b0, i_m}) ? (w_sum - {1'b0, i_m}) : w_sum;

    always_ff @(posedge i_clk) begin
        r_sum  <= n_sum[MB-1:0];
        r_x    <= i_x;
        r_prod <= r_sum * r_x;
    end

    ssg_modred #(
        .VALUE_BITS (VALUE_BITS)
    ) u_red (
        .i_clk (i_clk),
        .i_a   (r_prod),
        .i_m   (i_m),
        .i_mu  (i_mu),
        .o_r   (o_acc)
    );

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for shamir_share_generator: predicts each share by modular
// Horner evaluation and checks the strobed result over many modulus/degree settings.
// Depends on ssg_pkg and the shamir_share_generator RTL.
`timescale 1ns / 100ps

module tb_top;

    localparam int     PIPE_LAT    = ssg_pkg::RED_LAT
                                     + ssg_pkg::STEP_LAT * ssg_pkg::DEF_MAX_DEGREE + 1;
    localparam longint CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [ssg_pkg::X_BITS-1:0]                                   share_index;
        logic [ssg_pkg::DEF_VALUE_BITS-1:0]                           secret;
        logic [ssg_pkg::COEFF_FIELDS-1:0][ssg_pkg::DEF_VALUE_BITS-1:0] coeff; // [0] is x^1
    } t_share_req;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               start;
    logic                               busy;
    logic [ssg_pkg::X_BITS-1:0]         i_share_index;
    logic [ssg_pkg::DEF_VALUE_BITS-1:0] i_secret;
    logic [ssg_pkg::DEF_VALUE_BITS-1:0] i_coeff_1, i_coeff_2, i_coeff_3, i_coeff_4;
    logic [ssg_pkg::DEF_VALUE_BITS-1:0] i_coeff_5, i_coeff_6, i_coeff_7;
    logic                               o_share_valid;
    logic [ssg_pkg::MOD_FIELD_BITS-1:0] o_share;
    logic                               i_cfg_valid;
    logic                               o_cfg_ready;
    logic [ssg_pkg::IDX_BITS-1:0]       i_cfg_index;
    logic [ssg_pkg::MOD_FIELD_BITS-1:0] i_cfg_data;

    logic [ssg_pkg::MOD_FIELD_BITS-1:0] expected_shares[$];
    logic [ssg_pkg::MOD_FIELD_BITS-1:0] want_share;
    logic [ssg_pkg::MOD_FIELD_BITS-1:0] cur_modulus;
    logic [ssg_pkg::DEG_BITS-1:0]       cur_degree;
    int                                 idle_pct;
    int                                 fail_count;
    int                                 requests_sent;
    int                                 shares_checked;
    int                                 settings_used;
    longint                             cycle_count;

    shamir_share_generator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_share_index (i_share_index),
        .i_secret      (i_secret),
        .i_coeff_1     (i_coeff_1),
        .i_coeff_2     (i_coeff_2),
        .i_coeff_3     (i_coeff_3),
        .i_coeff_4     (i_coeff_4),
        .i_coeff_5     (i_coeff_5),
        .i_coeff_6     (i_coeff_6),
        .i_coeff_7     (i_coeff_7),
        .o_share_valid (o_share_valid),
        .o_share       (o_share),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // share checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_share_valid === 1'b1) begin
            if (expected_shares.size() == 0) begin
                $error("share: no word expected, actual %0d", o_share);
                fail_count++;
            end else begin
                want_share = expected_shares.pop_front();
                shares_checked++;
                if (o_share !== want_share) begin
                    $error("share mismatch: expected %0d, actual %0d", want_share, o_share);
                    fail_count++;
                end
            end
        end
    end

    function automatic logic [ssg_pkg::MOD_FIELD_BITS-1:0] predict_share(input t_share_req r);
        longint unsigned m;
        longint unsigned x;
        longint unsigned acc;
        longint unsigned c;
        int              d;
        int              k;
        m = cur_modulus;
        if (m == 0) return '0;
        d = cur_degree;
        if (d > ssg_pkg::DEF_MAX_DEGREE) d = ssg_pkg::DEF_MAX_DEGREE;
        if (d > ssg_pkg::COEFF_FIELDS) d = ssg_pkg::COEFF_FIELDS;
        x   = r.share_index % m;
        acc = 0;
        for (k = d; k >= 1; k--) begin
            c   = r.coeff[k-1] % m;
            acc = (acc + c) % m;
            acc = (acc * x) % m;
        end
        acc = (acc + r.secret % m) % m;
        return acc[ssg_pkg::MOD_FIELD_BITS-1:0];
    endfunction

    function automatic logic [ssg_pkg::DEF_VALUE_BITS-1:0] pick_operand();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return (cur_modulus > 0) ? cur_modulus - 1'b1 : '0;
            3: return cur_modulus;
            default: return ssg_pkg::DEF_VALUE_BITS'($urandom);
        endcase
    endfunction

    function automatic t_share_req random_request();
        t_share_req r;
        int         k;
        r.share_index = ssg_pkg::X_BITS'($urandom_range(0, 255));
        r.secret      = pick_operand();
        for (k = 0; k < ssg_pkg::COEFF_FIELDS; k++) r.coeff[k] = pick_operand();
        return r;
    endfunction

    task automatic send_share_request(input t_share_req r);
        start         <= 1'b1;
        i_share_index <= r.share_index;
        i_secret      <= r.secret;
        i_coeff_1     <= r.coeff[0];
        i_coeff_2     <= r.coeff[1];
        i_coeff_3     <= r.coeff[2];
        i_coeff_4     <= r.coeff[3];
        i_coeff_5     <= r.coeff[4];
        i_coeff_6     <= r.coeff[5];
        i_coeff_7     <= r.coeff[6];
        do @(posedge i_clk); while (busy !== 1'b0);
        expected_shares = {expected_shares, predict_share(r)};
        requests_sent++;
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic drain_shares();
        start <= 1'b0;
        do @(posedge i_clk); while (expected_shares.size() != 0);
    endtask

    task automatic write_register(input logic [ssg_pkg::IDX_BITS-1:0] idx,
                                  input logic [ssg_pkg::MOD_FIELD_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        if (idx == ssg_pkg::REG_MODULUS) cur_modulus = data;
        else cur_degree = data[ssg_pkg::DEG_BITS-1:0];
        @(posedge i_clk);
    endtask

    // only with the pipeline empty
    task automatic apply_setting(input int modulus, input int degree);
        drain_shares();
        repeat (PIPE_LAT) @(posedge i_clk);
        write_register(ssg_pkg::REG_DEGREE, {13'($urandom), 3'(degree)});
        write_register(ssg_pkg::REG_MODULUS, 16'(modulus));
        settings_used++;
    endtask

    task automatic test_reset_defaults();
        t_share_req r;
        idle_pct = 0;
        settings_used++;
        r = '0;
        send_share_request(r);
        r.share_index = 8'hFF;
        r.secret      = '1;
        r.coeff       = '1;
        send_share_request(r);
        r = random_request();
        r.share_index = '0;
        send_share_request(r);
        r          = '0;
        r.share_index = 8'd1;
        r.secret   = 16'd126;
        r.coeff[0] = 16'd1;
        r.coeff[6:2] = '1;
        send_share_request(r);
        r = random_request();
        r.share_index = 8'd127;
        send_share_request(r);
    endtask

    task automatic test_field_extremes();
        t_share_req r;
        idle_pct = 0;
        apply_setting(65535, 7);
        r = '1;
        send_share_request(r);
        r = '0;
        send_share_request(r);
        r = '1;
        r.share_index = '0;
        send_share_request(r);
        r.share_index = 8'hAA;
        r.secret      = 16'h5555;
        r.coeff       = {ssg_pkg::COEFF_FIELDS{16'hAAAA}};
        send_share_request(r);
        r.share_index = 8'h55;
        r.secret      = 16'hAAAA;
        r.coeff       = {ssg_pkg::COEFF_FIELDS{16'h5555}};
        send_share_request(r);
        apply_setting(65521, 7);
        r = '1;
        send_share_request(r);
    endtask

    task automatic test_degenerate_settings();
        idle_pct = 0;
        apply_setting(0, 7);
        send_share_request('1);
        send_share_request(random_request());
        apply_setting(1, 3);
        send_share_request('1);
        send_share_request(random_request());
        apply_setting(2, 7);
        send_share_request('1);
        apply_setting(65521, 0);
        send_share_request('1);
        send_share_request(random_request());
    endtask

    task automatic test_random_traffic(input int modulus, input int degree, input int pct,
                                       input int count, input bit pause_midway);
        int n;
        apply_setting(modulus, degree);
        idle_pct = pct;
        for (n = 0; n < count; n++) begin
            if (pause_midway && n == count / 2) drain_shares();
            send_share_request(random_request());
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_share_index = '0;
        i_secret      = '0;
        i_coeff_1     = '0;
        i_coeff_2     = '0;
        i_coeff_3     = '0;
        i_coeff_4     = '0;
        i_coeff_5     = '0;
        i_coeff_6     = '0;
        i_coeff_7     = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        cur_modulus   = ssg_pkg::MOD_RESET;
        cur_degree    = ssg_pkg::DEG_RESET;
        idle_pct      = 0;
        fail_count    = 0;
        requests_sent = 0;
        shares_checked = 0;
        settings_used = 0;
        cycle_count   = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_field_extremes();
        test_degenerate_settings();
        test_random_traffic(65521, 7, 0, 400, 1'b0);
        test_random_traffic($urandom_range(2, 65535), $urandom_range(0, 7), 87, 300, 1'b0);
        test_random_traffic(2, 3, 30, 200, 1'b1);
        test_random_traffic(65535, 0, 0, 200, 1'b0);
        test_random_traffic($urandom_range(2, 300), 5, 30, 300, 1'b0);
        test_random_traffic(127, 2, 87, 200, 1'b0);
        test_random_traffic($urandom_range(2, 65535), $urandom_range(0, 7), 0, 400, 1'b0);

        drain_shares();
        repeat (PIPE_LAT + 10) @(posedge i_clk);

        $display("Sent %0d share requests over %0d modulus/degree settings; %0d shares checked.",
                 requests_sent, settings_used, shares_checked);
        $display("Included zero and unit moduli, degrees 0 to 7, oversized operands and idle gaps.");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
